[rtl/rwm_pkg.sv]
// Shared types and constants for the RGB window median core.
`default_nettype none
package rwm_pkg;

  localparam int CHANNELS = 3;
  localparam int PIX_W = 8;
  localparam int SIDE_REG_W = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 1'b1;

  typedef logic [CHANNELS-1:0][PIX_W-1:0] rwm_chan_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_blue;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_red;
  } rwm_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] median_blue;
    logic [PIX_W-1:0] median_green;
    logic [PIX_W-1:0] median_red;
  } rwm_out_t;

  typedef struct packed {
    logic          occ;
    logic [CHANNELS-1:0] gt;
    rwm_chan_t     val;
  } rwm_link_t;

endpackage
`default_nettype wire

[rtl/rwm_cell.sv]
// One insertion-sort cell: holds one sorted entry of every channel.
`default_nettype none
module rwm_cell
  import rwm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      ins,
  input  wire logic      clr,
  input  wire rwm_chan_t pix,
  input  wire rwm_link_t left,
  output rwm_link_t      right
);

  logic      occ_r, occ_nxt;
  rwm_chan_t val_r, val_nxt;
  logic [CHANNELS-1:0] gt;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      gt[c] = ~occ_r | (val_r[c] > pix[c]);
    end
  end

  always_comb begin
    val_nxt = val_r;
    if (ins) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (gt[c]) begin
          val_nxt[c] = left.gt[c] ? left.val[c] : pix[c];
        end
      end
    end
  end

  always_comb begin
    if (clr) begin
      occ_nxt = 1'b0;
    end else if (ins) begin
      occ_nxt = occ_r | left.occ;
    end else begin
      occ_nxt = occ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign right.occ = occ_r;
  assign right.gt  = gt;
  assign right.val = val_r;

endmodule
`default_nettype wire

[rtl/rgb_window_median_core.sv]
// Top level of the RGB window median core: cell chain, pixel count and result register.
// Pixels of a window arrive in row-major order, one RGB pixel per transfer, and each
// is inserted into a chain of MAX_SIDE*MAX_SIDE sort cells in the cycle it is taken,
// so one pixel is accepted every clock unless stalled. After a window's last pixel pend_r
// is set and the three medians (entry floor(n/2) of each sorted channel) load into the
// result register once it is free; the input stalls only while a finished window waits
// behind a result held by out_stall. Writing kernel_width or kernel_height restarts the window.
`default_nettype none
module rgb_window_median_core
  import rwm_pkg::*;
#(
  parameter int MAX_SIDE = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire rwm_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output rwm_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [SIDE_REG_W-1:0] cfg_data
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);

  logic [SIDE_REG_W-1:0] kw_r, kw_nxt, kh_r, kh_nxt;
  logic [CNT_W-1:0]      taken_r, taken_nxt, taken_inc, win_n;
  logic [SIDE_W-1:0]     eff_w, eff_h;
  logic [IDX_W-1:0]      mid;
  logic                  pend_r, pend_nxt, out_valid_r, out_valid_nxt;
  rwm_out_t              out_r, out_nxt;
  logic                  in_acc, last, clr, out_free;
  rwm_chan_t             pix;
  rwm_link_t             link [DEPTH+1];
  rwm_chan_t             cell_val [DEPTH];

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_REG_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (32'(v) > MAX_SIDE) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = SIDE_W'(v);
    end
    return r;
  endfunction

  assign eff_w = clamp_side(kw_r);
  assign eff_h = clamp_side(kh_r);
  assign win_n = CNT_W'(eff_w) * CNT_W'(eff_h);
  assign mid   = IDX_W'(win_n >> 1);

  assign out_free  = ~out_valid_r | ~out_stall;
  assign in_stall  = pend_r & ~out_free;
  assign in_acc    = in_valid & ~in_stall;
  assign taken_inc = taken_r + CNT_W'(1);
  assign last      = in_acc & (taken_inc == win_n);
  assign clr       = last | cfg_we;

  assign pix[0] = in_data.pixel_blue;
  assign pix[1] = in_data.pixel_green;
  assign pix[2] = in_data.pixel_red;

  assign link[0].occ = 1'b1;
  assign link[0].gt  = '0;
  assign link[0].val = pix;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rwm_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ins   (in_acc),
      .clr   (clr),
      .pix   (pix),
      .left  (link[i]),
      .right (link[i+1])
    );
    assign cell_val[i] = link[i+1].val;
  end

  always_comb begin
    kw_nxt = kw_r;
    kh_nxt = kh_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_KERNEL_WIDTH:  kw_nxt = cfg_data;
        CFG_KERNEL_HEIGHT: kh_nxt = cfg_data;
        default:           kw_nxt = kw_r;
      endcase
    end
  end

  always_comb begin
    priority if (clr) begin
      taken_nxt = '0;
    end else if (in_acc) begin
      taken_nxt = taken_inc;
    end else begin
      taken_nxt = taken_r;
    end
  end

  always_comb begin
    pend_nxt      = (pend_r & ~out_free) | last;
    out_valid_nxt = (pend_r & out_free) | (out_valid_r & out_stall);
    out_nxt       = out_r;
    if (pend_r && out_free) begin
      out_nxt.median_blue  = cell_val[mid][0];
      out_nxt.median_green = cell_val[mid][1];
      out_nxt.median_red   = cell_val[mid][2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_r        <= SIDE_REG_W'(3);
      kh_r        <= SIDE_REG_W'(3);
      taken_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      kw_r        <= kw_nxt;
      kh_r        <= kh_nxt;
      taken_r     <= taken_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_below_window: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r < win_n)
    else $error("pixel count reached window size");

  a_last_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    last |=> pend_r)
    else $error("completed window not pending");

  a_pending_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && out_free) |=> out_valid_r)
    else $error("pending result not loaded");

  a_stall_only_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (pend_r && out_valid_r))
    else $error("input stalled without a held result");

endmodule
`default_nettype wire

[tb/tb_rgb_window_median_core.sv]
// Testbench for rgb_window_median_core: directed windows, then random kernel shapes and pixels.
module tb_rgb_window_median_core;
  import rwm_pkg::*;

  localparam int SIDE_MAX = 5;
  localparam int DEPTH = SIDE_MAX * SIDE_MAX;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PIXELS = 900;
  localparam int QUIET_SPAN = 150;

  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [SIDE_REG_W-1:0] val;
    rwm_in_t               pix;
    bit                    typed;
    rwm_out_t              want;
  } step_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  rwm_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  rwm_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [SIDE_REG_W-1:0] cfg_data;

  logic [SIDE_REG_W-1:0] kw;
  logic [SIDE_REG_W-1:0] kh;
  logic [PIX_W-1:0]      ranked [CHANNELS][DEPTH];
  int                    taken;

  rwm_out_t medians_due [$];
  step_t    script [$];
  string    field_name [CHANNELS] = '{"median_blue", "median_green", "median_red"};

  bit calm;
  int sent;
  int checked;
  int fails;
  int reg_writes;
  int pauses;

  rgb_window_median_core #(
    .MAX_SIDE(SIDE_MAX)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 19);
  end

  function automatic int side_of(logic [SIDE_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > SIDE_MAX) return SIDE_MAX;
    return int'(v);
  endfunction

  function automatic bit rank_pixel(input rwm_in_t p, output rwm_out_t m);
    int n;
    int pos;
    logic [PIX_W-1:0] v [CHANNELS];
    v[0] = p.pixel_blue;
    v[1] = p.pixel_green;
    v[2] = p.pixel_red;
    n = side_of(kw) * side_of(kh);
    m = '0;
    if (taken >= n) taken = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      pos = taken;
      while (pos > 0 && ranked[c][pos-1] > v[c]) begin
        ranked[c][pos] = ranked[c][pos-1];
        pos--;
      end
      ranked[c][pos] = v[c];
    end
    taken++;
    if (taken < n) return 0;
    m.median_blue = ranked[0][n/2];
    m.median_green = ranked[1][n/2];
    m.median_red = ranked[2][n/2];
    taken = 0;
    return 1;
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_REG_W-1:0] val);
    step_t s;
    s.is_reg = 1;
    s.idx = idx;
    s.val = val;
    s.pix = '0;
    s.typed = 0;
    s.want = '0;
    script.push_back(s);
  endfunction

  function automatic void add_px(logic [7:0] b, logic [7:0] g, logic [7:0] r, bit typed = 0,
                                 logic [7:0] mb = 0, logic [7:0] mg = 0, logic [7:0] mr = 0);
    step_t s;
    s.is_reg = 0;
    s.idx = CFG_KERNEL_WIDTH;
    s.val = '0;
    s.pix = '{b, g, r};
    s.typed = typed;
    s.want = '{mb, mg, mr};
    script.push_back(s);
  endfunction

  function automatic logic [7:0] pick_byte(int style, logic [7:0] base);
    case (style)
      1: begin
        return ($urandom_range(0, 1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(0, 1));
      end
      2: begin
        return base + 8'($urandom_range(0, 6));
      end
      default: begin
        return 8'($urandom);
      end
    endcase
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_REG_W-1:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_KERNEL_WIDTH) begin
      kw = val;
    end else begin
      kh = val;
    end
    taken = 0;
    reg_writes++;
    cfg_we <= 1'b0;
  endtask

  task automatic feed_pixel(rwm_in_t p, bit typed, rwm_out_t want);
    rwm_out_t m;
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if (rank_pixel(p, m)) medians_due.push_back(typed ? want : m);
  endtask

  always @(posedge clk) begin
    rwm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (medians_due.size() == 0) begin
        fails++;
        $display("%0t: result with none pending, expected nothing, actual %h", $time, out_data);
      end else begin
        want = medians_due.pop_front();
        checked++;
        for (int k = 0; k < CHANNELS; k++) begin
          if (out_data[PIX_W*(CHANNELS-k)-1 -: PIX_W] !== want[PIX_W*(CHANNELS-k)-1 -: PIX_W]) begin
            fails++;
            $display("%0t: %s expected %0d actual %0d", $time, field_name[k],
                     want[PIX_W*(CHANNELS-k)-1 -: PIX_W], out_data[PIX_W*(CHANNELS-k)-1 -: PIX_W]);
          end
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("[rgb_window_median_core] ERROR");
    $finish;
  end

  initial begin
    int n;
    int windows;
    int style;
    int target;
    int quiet_from;
    logic [7:0] base;
    rwm_in_t p;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_KERNEL_WIDTH;
    cfg_data = '0;
    calm = 0;
    kw = 3'd3;
    kh = 3'd3;
    taken = 0;

    for (int i = 0; i < 9; i++) begin
      add_px(8'(i * 30), 8'(255 - i * 30), (i % 2) ? 8'd255 : 8'd0, i == 8, 8'd120, 8'd135, 8'd0);
    end
    add_reg(CFG_KERNEL_WIDTH, 3'd0);
    add_reg(CFG_KERNEL_HEIGHT, 3'd1);
    add_px(8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h00, 8'h00);
    add_px(8'hFF, 8'hFF, 8'hFF, 1, 8'hFF, 8'hFF, 8'hFF);
    add_px(8'hAA, 8'h55, 8'h0F, 1, 8'hAA, 8'h55, 8'h0F);
    add_reg(CFG_KERNEL_WIDTH, 3'd3);
    add_reg(CFG_KERNEL_HEIGHT, 3'd0);
    add_px(8'd255, 8'd0, 8'd7);
    add_px(8'd0, 8'd255, 8'd3);
    add_px(8'd128, 8'd128, 8'd5, 1, 8'd128, 8'd128, 8'd5);
    add_reg(CFG_KERNEL_WIDTH, 3'd2);
    add_reg(CFG_KERNEL_HEIGHT, 3'd2);
    add_px(8'd1, 8'd1, 8'd1);
    add_px(8'd1, 8'd1, 8'd1);
    // restart the half-filled window
    add_reg(CFG_KERNEL_WIDTH, 3'd2);
    add_px(8'd40, 8'd4, 8'd0);
    add_px(8'd30, 8'd3, 8'd255);
    add_px(8'd20, 8'd2, 8'd255);
    add_px(8'd10, 8'd1, 8'd0, 1, 8'd30, 8'd3, 8'd255);
    add_reg(CFG_KERNEL_WIDTH, 3'd1);
    add_reg(CFG_KERNEL_HEIGHT, 3'd7);
    add_px(8'd50, 8'd10, 8'd200);
    add_px(8'd40, 8'd20, 8'd100);
    add_px(8'd30, 8'd30, 8'd0);
    add_px(8'd20, 8'd40, 8'd50);
    add_px(8'd10, 8'd50, 8'd150, 1, 8'd30, 8'd30, 8'd100);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[k]) begin
      if (script[k].is_reg) begin
        write_reg(script[k].idx, script[k].val);
      end else begin
        feed_pixel(script[k].pix, script[k].typed, script[k].want);
      end
    end

    target = sent + RANDOM_PIXELS;
    quiet_from = sent + RANDOM_PIXELS / 3;
    while (sent < target) begin
      if ($urandom_range(0, 3) != 0) begin
        write_reg(CFG_KERNEL_WIDTH, ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 3))
                                                               : 3'($urandom_range(4, 7)));
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(CFG_KERNEL_HEIGHT, ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 3))
                                                                : 3'($urandom_range(4, 7)));
      end
      n = side_of(kw) * side_of(kh);
      windows = (n > 12) ? $urandom_range(1, 2) : $urandom_range(1, 5);
      style = $urandom_range(0, 3);
      base = 8'($urandom);
      for (int w = 0; w < windows; w++) begin
        for (int k = 0; k < n; k++) begin
          calm = (sent >= quiet_from) && (sent < quiet_from + QUIET_SPAN);
          p = '{pick_byte(style, base), pick_byte(style, base), pick_byte(style, base)};
          feed_pixel(p, 0, '0);
        end
        if ($urandom_range(0, 9) == 0) begin
          settle();
          pauses++;
        end
      end
      // leave a broken window behind for the next register write to discard
      if (n > 1 && $urandom_range(0, 3) == 0) begin
        for (int k = $urandom_range(1, n - 1); k > 0; k--) begin
          p = '{pick_byte(style, base), pick_byte(style, base), pick_byte(style, base)};
          feed_pixel(p, 0, '0);
        end
      end
    end
    calm = 0;
    settle();

    $display("%0d pixels over %0d kernel register writes, %0d window medians checked",
             sent, reg_writes, checked);
    $display("sides 0..7 incl. clamped ones, restarted windows, %0d drained pauses", pauses);
    if (fails == 0) begin
      $display("[rgb_window_median_core] OK");
    end else begin
      $display("[rgb_window_median_core] ERROR");
    end
    $finish;
  end

endmodule
